### design/ire_pkg.sv
// ----------------------------------------------------------------------------
// ire_pkg
// Shared types, register indexes and segment decode for the IR frame encoder.
// ----------------------------------------------------------------------------
package ire_pkg;

  localparam int SegPerFrame  = 200;
  localparam int SegPerHalf   = 100;
  localparam int TrailMarkPos = SegPerHalf - 2;
  localparam int TrailGapPos  = SegPerHalf - 1;
  localparam int PayloadBits  = 48;

  localparam int DurW    = 16;
  localparam int SegIdxW = 8;
  localparam int CfgIdxW = 3;

  localparam logic [DurW-1:0] HdrMarkRst  = 16'd4400;
  localparam logic [DurW-1:0] HdrSpaceRst = 16'd4400;
  localparam logic [DurW-1:0] BitMarkRst  = 16'd550;
  localparam logic [DurW-1:0] OneSpaceRst = 16'd1660;
  localparam logic [DurW-1:0] ZeroSpcRst  = 16'd550;
  localparam logic [DurW-1:0] GapSpaceRst = 16'd5220;
  localparam logic [DurW-1:0] EndSpaceRst = 16'd8800;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HDR_MARK   = 3'd0,
    REG_HDR_SPACE  = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ONE_SPACE  = 3'd3,
    REG_ZERO_SPACE = 3'd4,
    REG_GAP_SPACE  = 3'd5,
    REG_END_SPACE  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [DurW-1:0] hdr_mark;
    logic [DurW-1:0] hdr_space;
    logic [DurW-1:0] bit_mark;
    logic [DurW-1:0] one_space;
    logic [DurW-1:0] zero_space;
    logic [DurW-1:0] gap_space;
    logic [DurW-1:0] end_space;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic start_refused;
  } res_t;

  // Tick count loaded for segment idx; a zero duration still lasts one tick.
  function automatic logic [DurW-1:0] seg_ticks(logic [SegIdxW-1:0] idx,
                                                logic [23:0] pay, cfg_t c);
    logic                   second;
    logic [6:0]             loc;
    logic [5:0]             k;
    logic [PayloadBits-1:0] v;
    logic [DurW-1:0]        d;
    second = (idx >= SegIdxW'(SegPerHalf));
    loc    = second ? 7'(idx - SegIdxW'(SegPerHalf)) : idx[6:0];
    k      = 6'((loc - 7'd2) >> 1);
    // transmission order: A, ~A, B, ~B, C, ~C, MSB first
    v = {pay[23:16], ~pay[23:16], pay[15:8], ~pay[15:8], pay[7:0], ~pay[7:0]};
    priority if (loc == 7'd0) begin
      d = c.hdr_mark;
    end else if (loc == 7'd1) begin
      d = c.hdr_space;
    end else if (loc == 7'(TrailMarkPos)) begin
      d = c.bit_mark;
    end else if (loc == 7'(TrailGapPos)) begin
      d = second ? c.end_space : c.gap_space;
    end else if (!loc[0]) begin
      d = c.bit_mark;
    end else begin
      d = v[6'(PayloadBits - 1) - k] ? c.one_space : c.zero_space;
    end
    return (d == '0) ? DurW'(1) : d;
  endfunction

endpackage

### design/ir_remote_frame_encoder_unit.sv
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit
// Timed mark/space envelope generator for a Coolix-style IR remote frame.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (valid/ready): command 1 starts a frame with byte_a..c,
//    command 0 is one time tick. A start while a frame is playing is refused.
//  - Each input transaction yields exactly one result transaction on the
//    output channel: line level during that tick, busy, frame done, refused.
//  - A frame is 200 segments (two half-frames of header, 48 bits, trailing
//    mark and gap/end space); each segment lasts its register's tick count,
//    or one tick when that register holds zero.
//  - Latency: the result is valid the cycle after the input is accepted.
//  - Throughput: one transaction per cycle unless the output stalls; the
//    whole step (counter decrement and next segment decode) sits between
//    the input handshake and the result register.
//  - Stall: while a result waits, a new input is taken only in the cycle the
//    receiver takes the waiting one, so ready follows out_ready_i.
//  - Reset: idle, no result pending, timing registers at their defaults.
//  - Configuration: a write on cfg_we_i lands at the next edge; index 7 is
//    ignored. Writes apply to segments loaded afterwards.
module ir_remote_frame_encoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ire_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ire_pkg::DurW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        command_i,
  input  logic [7:0]                  byte_a_i,
  input  logic [7:0]                  byte_b_i,
  input  logic [7:0]                  byte_c_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        line_level_o,
  output logic                        busy_res_o,
  output logic                        frame_done_o,
  output logic                        start_refused_o
);

  ire_pkg::cfg_t                  cfg_q;
  logic [ire_pkg::SegIdxW-1:0]    seg_q, seg_d;
  logic [ire_pkg::DurW-1:0]       ticks_q, ticks_d;
  logic [23:0]                    pay_q, pay_d;
  logic                           sending_q, sending_d;
  logic                           out_valid_q, out_valid_d;
  ire_pkg::res_t                  res_q, res_d;
  logic                           accept;
  logic [ire_pkg::SegIdxW-1:0]    seg_next;

  // Output register frees up whenever the receiver drains it.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign seg_next   = seg_q + ire_pkg::SegIdxW'(1);

  // Timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_mark   <= ire_pkg::HdrMarkRst;
      cfg_q.hdr_space  <= ire_pkg::HdrSpaceRst;
      cfg_q.bit_mark   <= ire_pkg::BitMarkRst;
      cfg_q.one_space  <= ire_pkg::OneSpaceRst;
      cfg_q.zero_space <= ire_pkg::ZeroSpcRst;
      cfg_q.gap_space  <= ire_pkg::GapSpaceRst;
      cfg_q.end_space  <= ire_pkg::EndSpaceRst;
    end else if (cfg_we_i) begin
      unique case (ire_pkg::reg_idx_e'(cfg_idx_i))
        ire_pkg::REG_HDR_MARK:   cfg_q.hdr_mark   <= cfg_data_i;
        ire_pkg::REG_HDR_SPACE:  cfg_q.hdr_space  <= cfg_data_i;
        ire_pkg::REG_BIT_MARK:   cfg_q.bit_mark   <= cfg_data_i;
        ire_pkg::REG_ONE_SPACE:  cfg_q.one_space  <= cfg_data_i;
        ire_pkg::REG_ZERO_SPACE: cfg_q.zero_space <= cfg_data_i;
        ire_pkg::REG_GAP_SPACE:  cfg_q.gap_space  <= cfg_data_i;
        ire_pkg::REG_END_SPACE:  cfg_q.end_space  <= cfg_data_i;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // One step of the frame sequencer per accepted transaction.
  always_comb begin
    seg_d     = seg_q;
    ticks_d   = ticks_q;
    pay_d     = pay_q;
    sending_d = sending_q;
    res_d     = '0;
    if (accept) begin
      if (command_i) begin
        res_d.busy_res = 1'b1;
        if (sending_q) begin
          res_d.start_refused = 1'b1;
        end else begin
          pay_d     = {byte_a_i, byte_b_i, byte_c_i};
          sending_d = 1'b1;
          seg_d     = '0;
          ticks_d   = ire_pkg::seg_ticks('0, {byte_a_i, byte_b_i, byte_c_i}, cfg_q);
        end
      end else if (sending_q) begin
        // even segments are marks
        res_d.line_level = ~seg_q[0];
        res_d.busy_res   = 1'b1;
        if (ticks_q > ire_pkg::DurW'(1)) begin
          ticks_d = ticks_q - ire_pkg::DurW'(1);
        end else if (seg_q == ire_pkg::SegIdxW'(ire_pkg::SegPerFrame - 1)) begin
          sending_d        = 1'b0;
          seg_d            = '0;
          ticks_d          = '0;
          res_d.frame_done = 1'b1;
        end else begin
          seg_d   = seg_next;
          ticks_d = ire_pkg::seg_ticks(seg_next, pay_q, cfg_q);
        end
      end
    end
  end

  always_comb begin
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q       <= '0;
      ticks_q     <= '0;
      pay_q       <= '0;
      sending_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      seg_q       <= seg_d;
      ticks_q     <= ticks_d;
      pay_q       <= pay_d;
      sending_q   <= sending_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, loaded with each accepted transaction.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign line_level_o    = res_q.line_level;
  assign busy_res_o      = res_q.busy_res;
  assign frame_done_o    = res_q.frame_done;
  assign start_refused_o = res_q.start_refused;

  // Assertions
  a_ticks_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sending_q |-> (ticks_q != '0))
    else $error("sending with zero ticks left");

  a_seg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q < ire_pkg::SegIdxW'(ire_pkg::SegPerFrame))
    else $error("segment index past end of frame");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sending_q |-> (seg_q == '0 && ticks_q == '0))
    else $error("idle with stale segment state");

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && res_d.frame_done) |=> !sending_q)
    else $error("frame done but still sending");

  a_refuse_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && command_i && sending_q) |=> (sending_q && $stable(pay_q)))
    else $error("refused start disturbed the frame");

endmodule

### verif/ir_remote_frame_encoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_remote_frame_encoder_unit_tb
// Self-checking bench for the IR frame envelope encoder. A driver feeds start
// and tick transactions in random bursts, a monitor takes results under a
// random stall pattern, and an in-bench envelope predictor works out the line
// level, busy, done and refused flags of every transaction. Timing registers
// are swept between phases, from all zero up to full scale.
// ----------------------------------------------------------------------------
module ir_remote_frame_encoder_unit_tb;

  localparam int DurW        = ire_pkg::DurW;
  localparam int SegIdxW     = ire_pkg::SegIdxW;
  localparam int CfgIdxW     = ire_pkg::CfgIdxW;
  localparam int SegPerFrame = ire_pkg::SegPerFrame;
  localparam int SegPerHalf  = ire_pkg::SegPerHalf;
  localparam int TrailGapPos = ire_pkg::TrailGapPos;

  // command codes on command_i
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // register index with no register behind it; writes there are dropped
  localparam logic [CfgIdxW-1:0] RegIdxNone = 3'd7;

  localparam int RandomItems = 450;
  // A run is about 1.5k to 2k transactions, under 3k at worst. Even under
  // the slowest stall pattern, plus sender gaps, this stays far below the
  // limit.
  localparam int CycleLimit  = 400_000;

  typedef struct {
    logic       cmd;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
  } ir_item_t;

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i   = '0;
  logic [DurW-1:0]    cfg_data_i  = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic               command_i   = CMD_TICK;
  logic [7:0]         byte_a_i    = '0;
  logic [7:0]         byte_b_i    = '0;
  logic [7:0]         byte_c_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               line_level_o;
  logic               busy_res_o;
  logic               frame_done_o;
  logic               start_refused_o;

  ir_remote_frame_encoder_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .byte_a_i       (byte_a_i),
    .byte_b_i       (byte_b_i),
    .byte_c_i       (byte_c_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .line_level_o   (line_level_o),
    .busy_res_o     (busy_res_o),
    .frame_done_o   (frame_done_o),
    .start_refused_o(start_refused_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Envelope predictor: own copy of timing registers and frame state
  // --------------------------------------------------------------------------
  logic [DurW-1:0]    dur_reg [7];
  logic               frame_on  = 1'b0;
  logic [SegIdxW-1:0] seg_idx   = '0;
  logic [DurW-1:0]    ticks_rem = '0;
  logic [23:0]        frame_pay = '0;

  initial begin
    dur_reg[ire_pkg::REG_HDR_MARK]   = ire_pkg::HdrMarkRst;
    dur_reg[ire_pkg::REG_HDR_SPACE]  = ire_pkg::HdrSpaceRst;
    dur_reg[ire_pkg::REG_BIT_MARK]   = ire_pkg::BitMarkRst;
    dur_reg[ire_pkg::REG_ONE_SPACE]  = ire_pkg::OneSpaceRst;
    dur_reg[ire_pkg::REG_ZERO_SPACE] = ire_pkg::ZeroSpcRst;
    dur_reg[ire_pkg::REG_GAP_SPACE]  = ire_pkg::GapSpaceRst;
    dur_reg[ire_pkg::REG_END_SPACE]  = ire_pkg::EndSpaceRst;
  end

  // Ticks spent in segment idx of a frame carrying pay.
  function automatic logic [DurW-1:0] seg_len(int idx, logic [23:0] pay);
    int          pos;
    int          bitno;
    logic [7:0]  cur_byte;
    logic [DurW-1:0] d;
    pos = idx % SegPerHalf;
    if (pos == 0) begin
      d = dur_reg[ire_pkg::REG_HDR_MARK];
    end else if (pos == 1) begin
      d = dur_reg[ire_pkg::REG_HDR_SPACE];
    end else if (pos == TrailGapPos) begin
      d = (idx >= SegPerHalf) ? dur_reg[ire_pkg::REG_END_SPACE]
                              : dur_reg[ire_pkg::REG_GAP_SPACE];
    end else if (pos % 2 == 0) begin
      // bit marks and the trailing mark
      d = dur_reg[ire_pkg::REG_BIT_MARK];
    end else begin
      // bits go A, ~A, B, ~B, C, ~C, MSB first
      bitno    = (pos - 2) / 2;
      cur_byte = 8'(pay >> (16 - 8 * (bitno / 16)));
      d = (cur_byte[7 - bitno % 8] ^ (bitno % 16 >= 8)) ? dur_reg[ire_pkg::REG_ONE_SPACE]
                                                         : dur_reg[ire_pkg::REG_ZERO_SPACE];
    end
    return (d == '0) ? DurW'(1) : d;
  endfunction

  function automatic int frame_len(logic [23:0] pay);
    int sum;
    sum = 0;
    for (int j = 0; j < SegPerFrame; j++) sum += int'(seg_len(j, pay));
    return sum;
  endfunction

  // Ticks still needed to finish the frame in flight (0 when idle).
  function automatic int ticks_to_finish();
    int sum;
    sum = 0;
    if (frame_on) begin
      sum = int'(ticks_rem);
      for (int j = int'(seg_idx) + 1; j < SegPerFrame; j++)
        sum += int'(seg_len(j, frame_pay));
    end
    return sum;
  endfunction

  function automatic ire_pkg::res_t step_envelope(logic cmd, logic [7:0] a,
                                                  logic [7:0] b, logic [7:0] c);
    ire_pkg::res_t r;
    r = '0;
    if (cmd == CMD_START) begin
      r.busy_res = 1'b1;
      if (frame_on) begin
        r.start_refused = 1'b1;
      end else begin
        frame_pay = {a, b, c};
        frame_on  = 1'b1;
        seg_idx   = '0;
        ticks_rem = seg_len(0, frame_pay);
      end
    end else if (frame_on) begin
      r.line_level = ~seg_idx[0];  // even segments are marks
      r.busy_res   = 1'b1;
      if (ticks_rem > DurW'(1)) begin
        ticks_rem = ticks_rem - DurW'(1);
      end else if (seg_idx == SegIdxW'(SegPerFrame - 1)) begin
        frame_on     = 1'b0;
        seg_idx      = '0;
        ticks_rem    = '0;
        r.frame_done = 1'b1;
      end else begin
        seg_idx   = seg_idx + SegIdxW'(1);
        ticks_rem = seg_len(int'(seg_idx), frame_pay);
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Queues and mismatch reporting
  // --------------------------------------------------------------------------
  ir_item_t      cmd_q[$];        // transactions waiting for the driver
  ire_pkg::res_t envelope_q[$];   // predicted results, oldest first
  int            pushed_cnt   = 0;
  int            mismatch_cnt = 0;

  task automatic flag_mismatch(input string what, input logic got, input logic want);
    mismatch_cnt++;
    $display("%0t: mismatch %s got %0b want %0b", $time, what, got, want);
  endtask

  // --------------------------------------------------------------------------
  // Driver: bursts of random length, random gaps between them
  // --------------------------------------------------------------------------
  ir_item_t next_item;
  int       burst_left = 1;
  int       gap_left   = 0;

  always @(posedge clk_i) begin
    // prediction happens on the accepting edge
    if (in_valid_i && in_ready_o)
      envelope_q.push_back(step_envelope(command_i, byte_a_i, byte_b_i, byte_c_i));
    if (!in_valid_i || in_ready_o) begin
      if (gap_left != 0 || cmd_q.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        next_item  = cmd_q.pop_front();
        in_valid_i <= 1'b1;
        command_i  <= next_item.cmd;
        byte_a_i   <= next_item.a;
        byte_b_i   <= next_item.b;
        byte_c_i   <= next_item.c;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(32, 1);
          gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: ready follows a stall mode that changes every stretch
  // --------------------------------------------------------------------------
  int          stall_mode = 0;
  int          stall_len  = 0;
  logic [15:0] stall_pat  = 16'h0001;

  always @(posedge clk_i) begin
    if (stall_len == 0) begin
      stall_mode = $urandom_range(3);
      stall_len  = $urandom_range(200, 20);
      stall_pat  = 16'($urandom) | 16'h0001;
    end
    stall_len--;
    stall_pat = {stall_pat[14:0], stall_pat[15]};
    case (stall_mode)
      0: begin
        out_ready_i <= 1'b1;  // no back-pressure
      end
      1: begin
        out_ready_i <= ($urandom_range(3) != 0);
      end
      2: begin
        out_ready_i <= stall_pat[0];
      end
      default: begin
        out_ready_i <= ($urandom_range(1) == 0);
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: compare each result with the oldest prediction
  // --------------------------------------------------------------------------
  ire_pkg::res_t want_res;

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (envelope_q.size() == 0) begin
        flag_mismatch("result with nothing expected", 1'b1, 1'b0);
      end else begin
        want_res = envelope_q.pop_front();
        if (line_level_o !== want_res.line_level)
          flag_mismatch("line_level", line_level_o, want_res.line_level);
        if (busy_res_o !== want_res.busy_res)
          flag_mismatch("busy_res", busy_res_o, want_res.busy_res);
        if (frame_done_o !== want_res.frame_done)
          flag_mismatch("frame_done", frame_done_o, want_res.frame_done);
        if (start_refused_o !== want_res.start_refused)
          flag_mismatch("start_refused", start_refused_o, want_res.start_refused);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  int cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("ir_remote_frame_encoder_unit_tb NOT OK");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(input logic cmd, input logic [7:0] a, input logic [7:0] b,
                           input logic [7:0] c);
    ir_item_t it;
    it.cmd = cmd;
    it.a   = a;
    it.b   = b;
    it.c   = c;
    cmd_q.push_back(it);
    pushed_cnt++;
  endtask

  // n ticks; with refuse_odds != 0 a start lands before some ticks, which
  // must be refused since the frame is still running there.
  task automatic push_ticks(input int n, input int refuse_odds);
    for (int i = 0; i < n; i++) begin
      if (refuse_odds != 0 && $urandom_range(refuse_odds - 1) == 0)
        push_item(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom));
      push_item(CMD_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Sender holds off until nothing is queued, in flight or expected.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid_i || envelope_q.size() != 0);
  endtask

  // Back-to-back register writes; end_writes drops the enable afterwards.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DurW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx != RegIdxNone) dur_reg[idx] = val;
  endtask

  task automatic end_writes();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // zero (one tick) half the time, else very short, so random frames stay small
  function automatic logic [DurW-1:0] pick_dur();
    return ($urandom_range(1) == 0) ? DurW'(0) : DurW'($urandom_range(3, 1));
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  int         rand_base;
  int         n;
  bit         first_round;
  logic [7:0] ra, rb, rc;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Tick while idle, timing registers still at their defaults.
    push_item(CMD_TICK, 8'hA5, 8'h5A, 8'hC3);
    wait_idle();

    // Short timing, then a start, a start while busy and a few header ticks.
    write_reg(ire_pkg::REG_HDR_MARK, 16'd8);
    write_reg(ire_pkg::REG_HDR_SPACE, 16'd3);
    write_reg(ire_pkg::REG_BIT_MARK, 16'd1);
    write_reg(ire_pkg::REG_ONE_SPACE, 16'd2);
    write_reg(ire_pkg::REG_ZERO_SPACE, 16'd1);
    write_reg(ire_pkg::REG_GAP_SPACE, 16'd3);
    write_reg(ire_pkg::REG_END_SPACE, 16'd2);
    end_writes();
    push_item(CMD_START, 8'hFF, 8'h00, 8'h5A);
    push_item(CMD_START, 8'h00, 8'hFF, 8'hA5);
    push_ticks(3, 0);
    wait_idle();

    // Rewrite every register mid-frame; the loaded header mark keeps its
    // length, later segments pick up the new values. Index 7 has no
    // register and must change nothing.
    write_reg(ire_pkg::REG_HDR_MARK, 16'd0);
    write_reg(ire_pkg::REG_HDR_SPACE, 16'd1);
    write_reg(ire_pkg::REG_BIT_MARK, 16'd0);
    write_reg(ire_pkg::REG_ONE_SPACE, 16'd2);
    write_reg(ire_pkg::REG_ZERO_SPACE, 16'd0);
    write_reg(ire_pkg::REG_GAP_SPACE, 16'd3);
    write_reg(ire_pkg::REG_END_SPACE, 16'd0);
    write_reg(RegIdxNone, 16'hFFFF);
    end_writes();
    push_ticks(ticks_to_finish(), 64);
    push_item(CMD_TICK, 8'h00, 8'h00, 8'h00);  // tick after the frame ends
    wait_idle();

    // All durations zero: every segment lasts one tick. A new start follows
    // the last tick right away.
    for (int r = ire_pkg::REG_HDR_MARK; r <= ire_pkg::REG_END_SPACE; r++)
      write_reg(CfgIdxW'(r), 16'd0);
    end_writes();
    push_item(CMD_START, 8'h00, 8'hFF, 8'h81);
    push_ticks(frame_len({8'h00, 8'hFF, 8'h81}), 0);
    push_item(CMD_START, 8'h3C, 8'hC3, 8'h96);
    push_ticks(frame_len({8'h3C, 8'hC3, 8'h96}), 0);
    wait_idle();

    // Long end space. Once inside it, load full scale everywhere else and
    // zero the end space: the segment already loaded must run its length.
    write_reg(ire_pkg::REG_END_SPACE, 16'd48);
    end_writes();
    push_item(CMD_START, 8'h55, 8'hAA, 8'h0F);
    push_ticks(SegPerFrame - 1 + 16, 0);
    wait_idle();
    for (int r = ire_pkg::REG_HDR_MARK; r < ire_pkg::REG_END_SPACE; r++)
      write_reg(CfgIdxW'(r), 16'hFFFF);
    write_reg(ire_pkg::REG_END_SPACE, 16'd0);
    end_writes();
    push_ticks(ticks_to_finish(), 0);

    // Random frames. Each round drains first; some rounds reload the timing,
    // some frames are cut short so the next round lands mid-frame.
    rand_base   = pushed_cnt;
    first_round = 1'b1;
    while (pushed_cnt - rand_base < RandomItems) begin
      wait_idle();
      if (first_round || $urandom_range(2) == 0) begin
        for (int r = ire_pkg::REG_HDR_MARK; r <= ire_pkg::REG_END_SPACE; r++)
          write_reg(CfgIdxW'(r), pick_dur());
        if ($urandom_range(7) == 0) write_reg(RegIdxNone, 16'($urandom));
        end_writes();
      end
      first_round = 1'b0;
      push_ticks(ticks_to_finish(), 16);
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(3, 1)) push_item(CMD_TICK, 8'($urandom), 8'($urandom),
                                                8'($urandom));
      end
      ra = 8'($urandom);
      rb = 8'($urandom);
      rc = 8'($urandom);
      push_item(CMD_START, ra, rb, rc);
      n = frame_len({ra, rb, rc});
      if ($urandom_range(5) == 0) n = $urandom_range(n - 1, 1);
      push_ticks(n, 20);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ir_remote_frame_encoder_unit_tb OK");
    end else begin
      $display("ir_remote_frame_encoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
